// ===== rtl/spf_pkg.sv =====
`default_nettype none
// ============================================================================
// spf_pkg
// Shared types and constants for the smallest prime factor sieve block.
// ============================================================================
package spf_pkg;

    // Fixed field widths of the request and result channels
    localparam int NUM_W = 17;
    localparam int CNT_W = 3;

    // Distinct prime count saturates here
    localparam logic [CNT_W-1:0] CNT_SAT = 3'd7;

    // Configuration port geometry and register map
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_TABLE_LIMIT = 2'd0;
    localparam logic [NUM_W-1:0] LIMIT_RST = 17'd65536;

    // Request opcodes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic build_start;  // latch limit, start clear pass at entry one
        logic clr_wr;       // clear entry r_i, advance r_i
        logic scan_init;    // scan starts at two
        logic scan_rd;      // read count of candidate r_i
        logic next_i;       // advance candidate
        logic mark_init;    // first multiple is the prime itself
        logic mark_rd;      // read count of multiple r_j
        logic mark_wr;      // update multiple r_j, step to next multiple
        logic build_done;   // tables now valid
        logic qry_rd;       // query accepted, read both tables
        logic out_qry;      // load output register from query stage
        logic out_bld;      // load output register with build result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic i_gt_lim;
        logic j_gt_lim;
        logic cnt_zero;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/smallest_prime_factor_sieve_top.sv =====
`default_nettype none
// ============================================================================
// smallest_prime_factor_sieve_top
// Smallest prime factor and distinct prime count tables with build and
// query requests and an APB-style limit register.
// ============================================================================
// Queries stream at one request per cycle while the output register drains. Each
// query is one read of the factor and count RAMs, which is registered, then
// loaded into the output register once that register is free.
// A build request holds off input for its whole run. The run is set by the
// single read/write port pair of the count RAM. It has a clear pass over
// entries 1..L (L = effective limit), a scan of the candidates 2..L, and a
// marking pass over the multiples of every prime p up to L. The result is
// then posted once the output register is free. Queries before the first
// build report not-ready. A limit write takes effect at the next build; before
// the first build the query range check uses the live limit.
module smallest_prime_factor_sieve_top #(
    parameter int MAX_LIMIT = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [spf_pkg::NUM_W-1:0]     i_query_number,
    // Result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [spf_pkg::NUM_W-1:0]     o_smallest_factor,
    output logic      [spf_pkg::CNT_W-1:0]     o_distinct_primes,
    output logic                               o_out_of_range,
    output logic                               o_ready_res,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [spf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [spf_pkg::PDATA_W-1:0]   pwdata,
    output logic      [spf_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [spf_pkg::NUM_W-1:0] r_table_limit;
    logic                      w_cfg_wr;
    spf_pkg::t_cmd             w_cmd;
    spf_pkg::t_sts             w_sts;

    // Limit register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr == spf_pkg::ADDR_TABLE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_limit <= spf_pkg::LIMIT_RST;
        end else if (w_cfg_wr) begin
            r_table_limit <= pwdata[spf_pkg::NUM_W-1:0];
        end
    end

    assign prdata = (paddr == spf_pkg::ADDR_TABLE_LIMIT) ?
                    spf_pkg::PDATA_W'(r_table_limit) : '0;

    // Sequencer
    spf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Tables and result path
    spf_dp #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_table_limit     (r_table_limit),
        .i_query_number    (i_query_number),
        .o_smallest_factor (o_smallest_factor),
        .o_distinct_primes (o_distinct_primes),
        .o_out_of_range    (o_out_of_range),
        .o_ready_res       (o_ready_res)
    );

    // A build request blocks further requests until it finishes
    a_build_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == spf_pkg::OP_BUILD)) |=> !o_in_ready)
        else $error("request accepted right after a build request");

    // At most one user of the count RAM ports in a cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.qry_rd, w_cmd.scan_rd, w_cmd.mark_rd, w_cmd.clr_wr,
                  w_cmd.mark_wr}))
        else $error("count RAM port conflict");

    // Build result is posted as ready with empty factor data
    a_build_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_bld |=> (o_out_valid && o_ready_res && !o_out_of_range &&
                           (o_smallest_factor == '0) && (o_distinct_primes == '0)))
        else $error("malformed build result");

endmodule
`default_nettype wire

// ===== rtl/spf_ram.sv =====
`default_nettype none
// ============================================================================
// spf_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/spf_ctrl.sv =====
`default_nettype none
// ============================================================================
// spf_ctrl
// Sequencer for the sieve build and handshake control for query requests.
// ============================================================================
module spf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_opcode,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire spf_pkg::t_sts i_sts,
    output spf_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CLEAR    = 7'b0000010,
        ST_SCAN_RD  = 7'b0000100,
        ST_SCAN_CHK = 7'b0001000,
        ST_MARK_RD  = 7'b0010000,
        ST_MARK_WR  = 7'b0100000,
        ST_DONE     = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic          r_s1_valid, n_s1_valid;
    logic          r_out_valid, n_out_valid;
    logic          w_out_free;
    logic          w_accept;
    spf_pkg::t_cmd w_cmd;

    // Output register frees up when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_s1_valid || w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.out_qry = r_s1_valid && w_out_free;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_opcode == spf_pkg::OP_QUERY)) begin
                    w_cmd.qry_rd = 1'b1;
                end
                if (w_accept && (i_opcode == spf_pkg::OP_BUILD)) begin
                    w_cmd.build_start = 1'b1;
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (i_sts.i_gt_lim) begin
                    w_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN_RD;
                end else begin
                    w_cmd.clr_wr = 1'b1;
                end
            end
            ST_SCAN_RD: begin
                if (i_sts.i_gt_lim) begin
                    n_state = ST_DONE;
                end else begin
                    w_cmd.scan_rd = 1'b1;
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                // An untouched count means no smaller prime divides it
                if (i_sts.cnt_zero) begin
                    w_cmd.mark_init = 1'b1;
                    n_state = ST_MARK_RD;
                end else begin
                    w_cmd.next_i = 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_MARK_RD: begin
                if (i_sts.j_gt_lim) begin
                    w_cmd.next_i = 1'b1;
                    n_state = ST_SCAN_RD;
                end else begin
                    w_cmd.mark_rd = 1'b1;
                    n_state = ST_MARK_WR;
                end
            end
            ST_MARK_WR: begin
                w_cmd.mark_wr = 1'b1;
                n_state = ST_MARK_RD;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_cmd.out_bld    = 1'b1;
                    w_cmd.build_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Query stage and output register occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_cmd.qry_rd) begin
            n_s1_valid = 1'b1;
        end else if (w_cmd.out_qry) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_cmd.out_qry || w_cmd.out_bld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule
`default_nettype wire

// ===== rtl/spf_dp.sv =====
`default_nettype none
// ============================================================================
// spf_dp
// Sieve datapath: factor and count tables, loop counters, query path and
// output register.
// ============================================================================
module spf_dp #(
    parameter int MAX_LIMIT = 65536
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire spf_pkg::t_cmd               i_cmd,
    output spf_pkg::t_sts                    o_sts,
    input  wire logic [spf_pkg::NUM_W-1:0]   i_table_limit,
    input  wire logic [spf_pkg::NUM_W-1:0]   i_query_number,
    output logic      [spf_pkg::NUM_W-1:0]   o_smallest_factor,
    output logic      [spf_pkg::CNT_W-1:0]   o_distinct_primes,
    output logic                             o_out_of_range,
    output logic                             o_ready_res
);

    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = AW + 1;
    localparam int CW    = (AW > spf_pkg::NUM_W) ? AW : spf_pkg::NUM_W;

    logic [AW-1:0]             r_lim;
    logic                      r_built;
    logic [IW-1:0]             r_i;
    logic [IW-1:0]             r_j;
    logic                      r_s1_oor, r_s1_rdy, r_s1_use;
    logic [spf_pkg::NUM_W-1:0] r_out_fac;
    logic [spf_pkg::CNT_W-1:0] r_out_cnt;
    logic                      r_out_oor, r_out_rdy;

    logic [CW-1:0]             w_tl_ext;
    logic [CW-1:0]             w_qn_ext;
    logic [AW-1:0]             w_eff_lim;
    logic [AW-1:0]             w_qry_lim;
    logic                      w_q_oor;
    logic [AW-1:0]             w_q_idx;
    logic [AW-1:0]             w_wr_idx;
    logic                      w_cnt_re, w_cnt_we, w_fac_we;
    logic [AW-1:0]             w_cnt_raddr;
    logic [spf_pkg::CNT_W-1:0] w_cnt_rd, w_cnt_wd;
    logic [AW-1:0]             w_fac_rd;
    logic [CW-1:0]             w_fac_ext;

    // Limit clamped to one through MAX_LIMIT
    assign w_tl_ext = CW'(i_table_limit);
    always_comb begin
        if (w_tl_ext == '0) begin
            w_eff_lim = AW'(1);
        end else if (w_tl_ext > CW'(MAX_LIMIT)) begin
            w_eff_lim = AW'(MAX_LIMIT);
        end else begin
            w_eff_lim = w_tl_ext[AW-1:0];
        end
    end

    // Query range check against the built limit, or the live one before a build
    assign w_qn_ext  = CW'(i_query_number);
    assign w_qry_lim = r_built ? r_lim : w_eff_lim;
    assign w_q_oor   = (w_qn_ext == '0) || (w_qn_ext > CW'(w_qry_lim));
    assign w_q_idx   = w_qn_ext[AW-1:0];

    // Table port muxing
    assign w_wr_idx    = i_cmd.clr_wr ? r_i[AW-1:0] : r_j[AW-1:0];
    assign w_cnt_re    = i_cmd.qry_rd || i_cmd.scan_rd || i_cmd.mark_rd;
    assign w_cnt_we    = i_cmd.clr_wr || i_cmd.mark_wr;
    assign w_fac_we    = i_cmd.clr_wr || (i_cmd.mark_wr && (w_cnt_rd == '0));
    assign w_cnt_raddr = i_cmd.qry_rd  ? w_q_idx :
                         i_cmd.scan_rd ? r_i[AW-1:0] : r_j[AW-1:0];

    // Saturating count update; clear pass writes zero
    always_comb begin
        if (i_cmd.clr_wr) begin
            w_cnt_wd = '0;
        end else if (w_cnt_rd == spf_pkg::CNT_SAT) begin
            w_cnt_wd = w_cnt_rd;
        end else begin
            w_cnt_wd = w_cnt_rd + spf_pkg::CNT_W'(1);
        end
    end

    // Clear writes n at entry n; marking writes the prime at its multiples not yet marked
    spf_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_fac_ram (
        .i_clk   (i_clk),
        .i_we    (w_fac_we),
        .i_waddr (w_wr_idx),
        .i_wdata (r_i[AW-1:0]),
        .i_re    (i_cmd.qry_rd),
        .i_raddr (w_q_idx),
        .o_rdata (w_fac_rd)
    );

    spf_ram #(
        .WIDTH (spf_pkg::CNT_W),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_wr_idx),
        .i_wdata (w_cnt_wd),
        .i_re    (w_cnt_re),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rd)
    );

    // Status to the sequencer
    assign o_sts.i_gt_lim = r_i > IW'(r_lim);
    assign o_sts.j_gt_lim = r_j > IW'(r_lim);
    assign o_sts.cnt_zero = (w_cnt_rd == '0);

    // Built flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built <= 1'b0;
        end else if (i_cmd.build_done) begin
            r_built <= 1'b1;
        end
    end

    // Limit latch and loop counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_start) begin
            r_lim <= w_eff_lim;
            r_i   <= IW'(1);
        end else if (i_cmd.scan_init) begin
            r_i   <= IW'(2);
        end else if (i_cmd.clr_wr || i_cmd.next_i) begin
            r_i   <= r_i + IW'(1);
        end
        if (i_cmd.mark_init) begin
            r_j <= r_i;
        end else if (i_cmd.mark_wr) begin
            r_j <= r_j + r_i;
        end
    end

    // Query stage flags, aligned with table read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.qry_rd) begin
            r_s1_oor <= w_q_oor;
            r_s1_rdy <= r_built;
            r_s1_use <= r_built && !w_q_oor;
        end
    end

    // Output register
    assign w_fac_ext = CW'(w_fac_rd);
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_qry) begin
            r_out_fac <= r_s1_use ? w_fac_ext[spf_pkg::NUM_W-1:0] : '0;
            r_out_cnt <= r_s1_use ? w_cnt_rd : '0;
            r_out_oor <= r_s1_oor;
            r_out_rdy <= r_s1_rdy;
        end else if (i_cmd.out_bld) begin
            r_out_fac <= '0;
            r_out_cnt <= '0;
            r_out_oor <= 1'b0;
            r_out_rdy <= 1'b1;
        end
    end

    assign o_smallest_factor = r_out_fac;
    assign o_distinct_primes = r_out_cnt;
    assign o_out_of_range    = r_out_oor;
    assign o_ready_res       = r_out_rdy;

endmodule
`default_nettype wire
